// File: rtl/core/hpve_pkg.sv
// ---------------------------------------------------------------------------
// hpve_pkg
// Shared widths, reset values and codes of the hall period velocity
// estimator.
// ---------------------------------------------------------------------------
package hpve_pkg;

    localparam int HPVE_COUNT_WIDTH    = 20;
    localparam int HPVE_GAIN_WIDTH     = 26;
    localparam int HPVE_LIMIT_WIDTH    = 16;
    localparam int HPVE_TIMEOUT_WIDTH  = 20;
    localparam int HPVE_VEL_WIDTH      = 17;
    localparam int HPVE_CODE_WIDTH     = 3;
    localparam int HPVE_CFG_IDX_WIDTH  = 2;
    localparam int HPVE_CFG_DATA_WIDTH = 26;

    localparam logic [HPVE_GAIN_WIDTH-1:0]    HPVE_GAIN_RESET    = 26'd4363635;
    localparam logic [HPVE_LIMIT_WIDTH-1:0]   HPVE_LIMIT_RESET   = 16'd64000;
    localparam logic [HPVE_TIMEOUT_WIDTH-1:0] HPVE_TIMEOUT_RESET = 20'd40000;

    // configuration register indexes
    typedef enum logic [HPVE_CFG_IDX_WIDTH-1:0] {
        HPVE_REG_VELOCITY_GAIN  = 2'd0,
        HPVE_REG_VELOCITY_LIMIT = 2'd1,
        HPVE_REG_STOP_TIMEOUT   = 2'd2
    } hpve_reg_t;

endpackage

// File: rtl/core/hpve_if.sv
// ---------------------------------------------------------------------------
// hpve_if
// Valid/ready channels of the estimator: hall sample in, velocity out.
// ---------------------------------------------------------------------------
interface hpve_sample_if;
    logic valid;
    logic ready;
    logic hall_u;
    logic hall_v;
    logic hall_w;
    logic clockwise;

    modport source (output valid, output hall_u, output hall_v, output hall_w,
                    output clockwise, input ready);
    modport sink   (input valid, input hall_u, input hall_v, input hall_w,
                    input clockwise, output ready);
endinterface

interface hpve_result_if;
    logic                                        valid;
    logic                                        ready;
    logic        [hpve_pkg::HPVE_CODE_WIDTH-1:0] hall_code;
    logic signed [hpve_pkg::HPVE_VEL_WIDTH-1:0]  velocity;

    modport source (output valid, output hall_code, output velocity, input ready);
    modport sink   (input valid, input hall_code, input velocity, output ready);
endinterface

// File: rtl/core/hpve_div.sv
// ---------------------------------------------------------------------------
// hpve_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ---------------------------------------------------------------------------
module hpve_div #(
    parameter int DIVIDEND_WIDTH = hpve_pkg::HPVE_GAIN_WIDTH,
    parameter int DIVISOR_WIDTH  = hpve_pkg::HPVE_COUNT_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic                      done,
    output logic [DIVIDEND_WIDTH-1:0] quotient
);

    localparam int CNT_WIDTH = (DIVIDEND_WIDTH > 1) ? $clog2(DIVIDEND_WIDTH) : 1;
    localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(DIVIDEND_WIDTH - 1);

    logic                      busy_reg,  busy_next;
    logic                      done_reg,  done_next;
    logic [CNT_WIDTH-1:0]      cnt_reg,   cnt_next;
    logic [DIVIDEND_WIDTH-1:0] dq_reg,    dq_next;
    logic [DIVISOR_WIDTH-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_WIDTH-1:0]  dvs_reg,   dvs_next;
    logic [DIVISOR_WIDTH:0]    trial;
    logic [DIVISOR_WIDTH:0]    diff;
    logic                      qbit;

    // shift one dividend bit into the partial remainder
    assign trial = {rem_reg, dq_reg[DIVIDEND_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = !diff[DIVISOR_WIDTH];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[DIVIDEND_WIDTH-2:0], qbit};
            rem_next = qbit ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// File: rtl/core/hall_period_velocity_estimator.sv
// ---------------------------------------------------------------------------
// hall_period_velocity_estimator
// Times W hall half periods in sample ticks and turns them into a signed
// velocity (rpm, four fractional bits) with a bit-serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   samples : one transfer per sample tick carrying hall_u/v/w and clockwise.
//   result  : one transfer per sample, hall_code (U,V,W) and held velocity.
//   cfg_*   : write velocity_gain, velocity_limit, stop_timeout by index while
//             the block is idle; an unknown index is dropped.
// Timing:
//   A tick without a W edge, or an edge with a zero count, passes through
//   the ST_DONE state into the result register, and the next sample is
//   taken only after the block has returned to idle.
//   A W edge with a nonzero count runs the serial divider, one quotient bit
//   per cycle over the 26 gain bits, then passes ST_DONE into the result
//   register; the block takes no new sample until it has returned to idle.
// Reset clears the tick counter, the stored W level and the held velocity,
// and loads the default gain, limit and timeout.
// A stalled receiver holds the result register; one more sample may still
// be processed and then waits until the register drains.
// ---------------------------------------------------------------------------
module hall_period_velocity_estimator #(
    parameter int COUNT_WIDTH = hpve_pkg::HPVE_COUNT_WIDTH
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    hpve_sample_if.sink                              samples,
    hpve_result_if.source                            result,
    input  logic                                     cfg_we,
    input  logic [hpve_pkg::HPVE_CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [hpve_pkg::HPVE_CFG_DATA_WIDTH-1:0] cfg_data
);

    localparam int GAIN_W  = hpve_pkg::HPVE_GAIN_WIDTH;
    localparam int LIMIT_W = hpve_pkg::HPVE_LIMIT_WIDTH;
    localparam int TOUT_W  = hpve_pkg::HPVE_TIMEOUT_WIDTH;
    localparam int VEL_W   = hpve_pkg::HPVE_VEL_WIDTH;
    localparam int CODE_W  = hpve_pkg::HPVE_CODE_WIDTH;
    // compare width for count + 1 against the timeout
    localparam int CMP_W   = (COUNT_WIDTH + 1 > TOUT_W) ? COUNT_WIDTH + 1 : TOUT_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    state_t                    state_reg, state_next;

    // configuration
    logic [GAIN_W-1:0]         gain_reg;
    logic [LIMIT_W-1:0]        limit_reg;
    logic [TOUT_W-1:0]         timeout_reg;

    // tracking state
    logic [COUNT_WIDTH-1:0]    count_reg,  count_next;
    logic                      last_w_reg, last_w_next;
    logic [VEL_W-1:0]          held_reg,   held_next;

    // item in flight
    logic [CODE_W-1:0]         code_reg,   code_next;
    logic                      cw_reg,     cw_next;
    logic [VEL_W-1:0]          res_reg,    res_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]         out_code_reg,  out_code_next;
    logic [VEL_W-1:0]          out_vel_reg,   out_vel_next;

    logic                      accept;
    logic                      out_free;
    logic [COUNT_WIDTH:0]      count_inc;
    logic                      timeout_hit;
    logic                      div_start;
    logic                      div_done;
    logic [GAIN_W-1:0]         quotient;
    logic [LIMIT_W-1:0]        magnitude;
    logic [VEL_W-1:0]          mag_ext;
    logic [VEL_W-1:0]          signed_vel;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign samples.ready = (state_reg == ST_IDLE);

    assign count_inc   = {1'b0, count_reg} + 1'b1;
    assign timeout_hit = CMP_W'(count_inc) > CMP_W'(timeout_reg);

    // clamp the quotient, then negate for clockwise rotation
    assign magnitude  = (quotient > GAIN_W'(limit_reg)) ? limit_reg : quotient[LIMIT_W-1:0];
    assign mag_ext    = {{(VEL_W - LIMIT_W){1'b0}}, magnitude};
    assign signed_vel = cw_reg ? (~mag_ext + 1'b1) : mag_ext;

    hpve_div #(
        .DIVIDEND_WIDTH (GAIN_W),
        .DIVISOR_WIDTH  (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (gain_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_w_next    = last_w_reg;
        held_next      = held_reg;
        code_next      = code_reg;
        cw_next        = cw_reg;
        res_next       = res_reg;
        out_code_next  = out_code_reg;
        out_vel_next   = out_vel_reg;
        out_valid_next = out_valid_reg && !result.ready;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    code_next = {samples.hall_u, samples.hall_v, samples.hall_w};
                    cw_next   = samples.clockwise;
                    state_next = ST_DONE;
                    if (samples.hall_w == last_w_reg)
                    begin
                        if (timeout_hit)
                        begin
                            // motor stopped: drop count and velocity
                            count_next = '0;
                            held_next  = '0;
                            res_next   = '0;
                        end
                        else
                        begin
                            // saturate at full scale
                            count_next = count_inc[COUNT_WIDTH] ? '1
                                                                : count_inc[COUNT_WIDTH-1:0];
                            res_next   = held_reg;
                        end
                    end
                    else
                    begin
                        last_w_next = samples.hall_w;
                        count_next  = '0;
                        if (count_reg != '0)
                        begin
                            // divider latches count_reg before it clears
                            div_start  = 1'b1;
                            state_next = ST_DIVIDE;
                        end
                        else
                        begin
                            held_next = '0;
                            res_next  = '0;
                        end
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    held_next  = signed_vel;
                    res_next   = signed_vel;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = code_reg;
                    out_vel_next   = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_w_reg    <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_w_reg    <= last_w_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= hpve_pkg::HPVE_GAIN_RESET;
            limit_reg   <= hpve_pkg::HPVE_LIMIT_RESET;
            timeout_reg <= hpve_pkg::HPVE_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hpve_pkg::HPVE_REG_VELOCITY_GAIN:  gain_reg    <= cfg_data[GAIN_W-1:0];
                hpve_pkg::HPVE_REG_VELOCITY_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                hpve_pkg::HPVE_REG_STOP_TIMEOUT:   timeout_reg <= cfg_data[TOUT_W-1:0];
                default:
                begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        cw_reg       <= cw_next;
        res_reg      <= res_next;
        out_code_reg <= out_code_next;
        out_vel_reg  <= out_vel_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.hall_code = out_code_reg;
    assign result.velocity  = out_vel_reg;

endmodule
